// File: rtl/core/wit_pkg.sv
// Package for the watchdog/interval timer: operation and register codes,
// register bit constants and the prescaler tap function.
// No dependencies.
package wit_pkg;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpRead  = 2'd1,
    OpWrite = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    SelCtrlStat = 2'd0,
    SelCounter  = 2'd1,
    SelRstBase  = 2'd2,
    SelRstByte  = 2'd3
  } reg_sel_e;

  localparam logic [7:0] KeyCtrl    = 8'hA5;
  localparam logic [7:0] KeyData    = 8'h5A;
  localparam logic [7:0] CsWrMask   = 8'h67;
  localparam logic [7:0] CsRdSet    = 8'h18;
  localparam logic [5:0] RsRdSet    = 6'h3F;
  localparam logic [7:0] Unmapped   = 8'hFF;
  localparam logic [7:0] CountMax   = 8'hFF;
  localparam int unsigned PreWidth  = 12;

  // Control/status bit positions.
  localparam int unsigned CsOvf = 7;
  localparam int unsigned CsWdt = 6;
  localparam int unsigned CsTme = 5;
  // Reset status bit position of the output enable in written data.
  localparam int unsigned RsOe  = 6;

  // Low prescaler bits that must all be zero for the counter to advance.
  function automatic logic [PreWidth-1:0] pre_mask(input logic [2:0] cks);
    logic [PreWidth-1:0] m;
    m = '0;
    case (cks)
      3'd0:    m = 12'h001;
      3'd1:    m = 12'h01F;
      3'd2:    m = 12'h03F;
      3'd3:    m = 12'h07F;
      3'd4:    m = 12'h0FF;
      3'd5:    m = 12'h1FF;
      3'd6:    m = 12'h7FF;
      default: m = 12'hFFF;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/core/wit_req_if.sv
// Request channel of the watchdog/interval timer: valid/ready and the item
// fields. Depends on nothing.
interface wit_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [1:0] reg_select;
  logic [7:0] write_key;
  logic [7:0] write_data;

  modport source (output valid, opcode, reg_select, write_key, write_data, input ready);
  modport sink   (input valid, opcode, reg_select, write_key, write_data, output ready);
endinterface

// File: rtl/core/wit_rsp_if.sv
// Result channel of the watchdog/interval timer: valid/ready and the result
// fields. Depends on nothing.
interface wit_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_request;
  logic       chip_reset;

  modport source (output valid, read_data, irq_request, chip_reset, input ready);
  modport sink   (input valid, read_data, irq_request, chip_reset, output ready);
endinterface

// File: rtl/core/watchdog_interval_timer.sv
// Path: a request passes the input register, then the result register; timer
// state updates on the same edge as the result register loads.
// Throughput: one item per cycle, limited only by rsp_o.ready.
// Reset (rst_ni low, async): timer, control/status, reset status and both
// stages' valid flags clear; the reset status register present flag sets to 1.
// Depends on wit_pkg, wit_req_if, wit_rsp_if.
module watchdog_interval_timer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  wit_req_if.sink    req_i,
  wit_rsp_if.source  rsp_o
);

  // Configuration
  logic has_rsr_q;

  // Input stage
  logic       in_valid_q;
  logic [1:0] op_q;
  logic [1:0] sel_q;
  logic [7:0] key_q;
  logic [7:0] data_q;

  // Timer state
  logic [7:0]                   count_q, count_d;
  logic [7:0]                   cs_q, cs_d;
  logic                         cause_q, cause_d;
  logic                         oe_q, oe_d;
  logic                         seen_q, seen_d;
  logic [wit_pkg::PreWidth-1:0] pre_q, pre_d;

  // Result stage
  logic       out_valid_q;
  logic [7:0] rd_q, rd_d;
  logic       irq_q, irq_d;
  logic       rst_q, rst_d;

  logic advance;
  logic step;
  logic [wit_pkg::PreWidth-1:0] pre_inc;
  logic                         wrap_hit;

  assign advance     = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !in_valid_q || advance;
  assign step        = in_valid_q && advance;

  assign pre_inc  = pre_q + 1'b1;
  assign wrap_hit = (pre_inc & wit_pkg::pre_mask(cs_q[2:0])) == '0;

  always_comb begin
    count_d = count_q;
    cs_d    = cs_q;
    cause_d = cause_q;
    oe_d    = oe_q;
    seen_d  = seen_q;
    pre_d   = pre_q;
    rd_d    = 8'h00;
    rst_d   = 1'b0;

    case (wit_pkg::op_e'(op_q))
      wit_pkg::OpTick: begin
        pre_d = pre_inc;
        if (cs_q[wit_pkg::CsTme] && wrap_hit) begin
          if (count_q != wit_pkg::CountMax) begin
            count_d = count_q + 8'd1;
          end else if (cs_q[wit_pkg::CsWdt]) begin
            // Watchdog expiry: record cause, pulse chip reset, clear the timer.
            cause_d = 1'b1;
            rst_d   = 1'b1;
            count_d = '0;
            cs_d    = '0;
            seen_d  = 1'b0;
            pre_d   = '0;
          end else begin
            count_d            = '0;
            cs_d[wit_pkg::CsOvf] = 1'b1;
          end
        end
      end
      wit_pkg::OpRead: begin
        case (wit_pkg::reg_sel_e'(sel_q))
          wit_pkg::SelCtrlStat: begin
            if (cs_q[wit_pkg::CsOvf]) seen_d = 1'b1;
            rd_d = cs_q | wit_pkg::CsRdSet;
          end
          wit_pkg::SelCounter: rd_d = count_q;
          wit_pkg::SelRstByte: rd_d = has_rsr_q ? {cause_q, oe_q, wit_pkg::RsRdSet}
                                                : wit_pkg::Unmapped;
          default: rd_d = wit_pkg::Unmapped;
        endcase
      end
      wit_pkg::OpWrite: begin
        if (wit_pkg::reg_sel_e'(sel_q) == wit_pkg::SelCtrlStat) begin
          if (key_q == wit_pkg::KeyCtrl) begin
            // Overflow flag clears only on a zero write after it was read as one.
            cs_d = (data_q & wit_pkg::CsWrMask);
            cs_d[wit_pkg::CsOvf] = cs_q[wit_pkg::CsOvf] &&
                                   !(!data_q[wit_pkg::CsOvf] && seen_q);
            seen_d = 1'b0;
            if (!data_q[wit_pkg::CsTme]) count_d = '0;
          end else if (key_q == wit_pkg::KeyData) begin
            count_d = data_q;
          end
        end else if (wit_pkg::reg_sel_e'(sel_q) == wit_pkg::SelRstBase && has_rsr_q) begin
          if (key_q == wit_pkg::KeyCtrl && data_q == 8'h00) begin
            cause_d = 1'b0;
          end else if (key_q == wit_pkg::KeyData) begin
            oe_d = data_q[wit_pkg::RsOe];
          end
        end
      end
      default: ;
    endcase

    irq_d = cs_d[wit_pkg::CsOvf] && !cs_d[wit_pkg::CsWdt];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_rsr_q   <= 1'b1;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      cs_q        <= '0;
      cause_q     <= 1'b0;
      oe_q        <= 1'b0;
      seen_q      <= 1'b0;
      pre_q       <= '0;
    end else begin
      if (cfg_we_i) has_rsr_q <= cfg_wdata_i;
      if (req_i.ready) in_valid_q <= req_i.valid;
      if (advance) out_valid_q <= in_valid_q;
      if (step) begin
        count_q <= count_d;
        cs_q    <= cs_d;
        cause_q <= cause_d;
        oe_q    <= oe_d;
        seen_q  <= seen_d;
        pre_q   <= pre_d;
      end
    end
  end

  // Payload registers: hold while stalled.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q   <= req_i.opcode;
      sel_q  <= req_i.reg_select;
      key_q  <= req_i.write_key;
      data_q <= req_i.write_data;
    end
    if (step) begin
      rd_q  <= rd_d;
      irq_q <= irq_d;
      rst_q <= rst_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_data   = rd_q;
  assign rsp_o.irq_request = irq_q;
  assign rsp_o.chip_reset  = rst_q;

endmodule

// File: rtl/core/wit_checker.sv
// Port-level checks for the watchdog/interval timer, bound to the top level.
// Depends on watchdog_interval_timer and its channel interfaces.
module wit_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [7:0] rsp_read_data_i,
  input logic       rsp_irq_i,
  input logic       rsp_chip_reset_i
);

  // A stalled result holds until its transfer.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i &&
      $stable(rsp_read_data_i) && $stable(rsp_irq_i) && $stable(rsp_chip_reset_i))
    else $error("result changed while stalled");

  // Only a stalled result may back-pressure the request side.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> rsp_valid_i && !rsp_ready_i)
    else $error("request stalled without output back-pressure");

  // A watchdog reset result carries zero read data and no irq.
  a_reset_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_chip_reset_i |-> rsp_read_data_i == 8'h00 && !rsp_irq_i)
    else $error("chip reset result carries read data or irq");

  // No result right out of reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !rsp_valid_i)
    else $error("result valid right after reset");

endmodule

bind watchdog_interval_timer wit_checker u_wit_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_read_data_i  (rsp_o.read_data),
  .rsp_irq_i        (rsp_o.irq_request),
  .rsp_chip_reset_i (rsp_o.chip_reset)
);
